// File: rtl/core/first_fit_heap_allocator_defines.svh
// ----------------------------------------------------------------------------
// first fit heap allocator: assertion macros
// concurrent checks, compiled away when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`ifndef SYNTH
`define FFHA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FFHA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FFHA_ASSERT(label, clk, rst, prop, msg)
`define FFHA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: rtl/core/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// shared widths, codes, sequencer states and the engine result bundle
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

   localparam int ADDR_W         = 10;
   localparam int SIZE_W         = 16;
   localparam int STATUS_W       = 2;
   localparam int HEAP_UNITS_DEF = 1024;
   localparam int UNIT_BYTES_DEF = 16;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_SPACE   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_ADDR   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_IN_USE = 2'd3;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_WALK_RD,
      ST_WALK_CHK,
      ST_SPLIT_LINK,
      ST_SPLIT_NEW,
      ST_FREE_H,
      ST_FREE_N,
      ST_FREE_P,
      ST_FREE_WH,
      ST_FREE_WX,
      ST_FREE_WN,
      ST_FREE_WP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                valid;
      logic [ADDR_W-1:0]   result_address;
      logic [STATUS_W-1:0] status;
   } eng_rsp_type;

endpackage

`default_nettype wire

// File: rtl/core/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// first-fit heap allocator with coalescing over a chain of header units
// ----------------------------------------------------------------------------
//  channel   direction  ports
//  req       in         req_valid/req_ready, operation, size_bytes, payload_address
//  rsp       out        rsp_valid/rsp_ready, result_address, status
//
//  allocate: the request is taken, the unit count is formed, then each chain
//  block visited takes one header ram read; a miss ends at the sentinel, a
//  split adds a relink of the next header and a new header, then the result
//  is handed over. free: the header and its neighbours are read, then written.
//  after reset a clearing pass writes all HEAP_UNITS headers, one per cycle,
//  and no request is taken until it ends.
//  the output register lets the next request start while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_heap_allocator #(
   parameter int HEAP_UNITS = ffha_pkg::HEAP_UNITS_DEF,
   parameter int UNIT_BYTES = ffha_pkg::UNIT_BYTES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_operation,
   input  wire logic [ffha_pkg::SIZE_W-1:0]   req_size_bytes,
   input  wire logic [ffha_pkg::ADDR_W-1:0]   req_payload_address,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [ffha_pkg::ADDR_W-1:0]   rsp_result_address,
   output logic      [ffha_pkg::STATUS_W-1:0] rsp_status
);

   import ffha_pkg::*;

   eng_rsp_type         eng_rsp;
   logic                out_free;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   ffha_engine #(
      .HEAP_UNITS (HEAP_UNITS),
      .UNIT_BYTES (UNIT_BYTES)
   ) u_engine (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_size_bytes      (req_size_bytes),
      .req_payload_address (req_payload_address),
      .eng_rsp             (eng_rsp),
      .out_free            (out_free)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      if (out_free) begin
         rsp_valid_in = eng_rsp.valid;
         if (eng_rsp.valid) begin
            rsp_addr_in   = eng_rsp.result_address;
            rsp_status_in = eng_rsp.status;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_status         = rsp_status_ff;

endmodule

`default_nettype wire

// File: rtl/core/ffha_ram.sv
// ----------------------------------------------------------------------------
// ffha_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_ram #(
   parameter int WIDTH = 2 * $clog2(ffha_pkg::HEAP_UNITS_DEF) + 2,
   parameter int DEPTH = ffha_pkg::HEAP_UNITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/ffha_units_div.sv
// ----------------------------------------------------------------------------
// ffha_units_div
// unit count of a byte request, rounded up, by reciprocal multiplication
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_units_div #(
   parameter int UNIT_BYTES = ffha_pkg::UNIT_BYTES_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [ffha_pkg::SIZE_W-1:0] bytes,
   output logic                             done,
   output logic      [ffha_pkg::SIZE_W:0]   units
);

   import ffha_pkg::*;

   localparam int NUM_W   = SIZE_W + 1;
   localparam int SHIFT   = NUM_W + $clog2(UNIT_BYTES);
   localparam int RECIP_W = NUM_W + 1;
   localparam int PROD_W  = NUM_W + RECIP_W;
   // ceiling of 2^SHIFT / UNIT_BYTES, exact quotient for every NUM_W-bit numerator
   localparam longint unsigned RECIP =
      ((64'd1 << SHIFT) + 64'(UNIT_BYTES) - 64'd1) / 64'(UNIT_BYTES);

   logic [NUM_W-1:0]  num;
   logic [PROD_W-1:0] prod;
   logic [NUM_W-1:0]  quo;
   logic              done_ff;
   logic [NUM_W-1:0]  units_ff, units_in;

   always_comb begin
      num  = NUM_W'(bytes) + NUM_W'(UNIT_BYTES - 1);
      prod = PROD_W'(num) * PROD_W'(RECIP);
      quo  = NUM_W'(prod >> SHIFT);
      units_in = units_ff;
      if (start) begin
         // a zero-byte request still gets one unit
         units_in = (quo == '0) ? NUM_W'(1) : quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= start;
      end
      units_ff <= units_in;
   end

   assign done  = done_ff;
   assign units = units_ff;

endmodule

`default_nettype wire

// File: rtl/core/ffha_engine.sv
// ----------------------------------------------------------------------------
// ffha_engine
// header store sequencer: clearing pass, first-fit walk with split, and
// free with merge of both neighbours, all through one header ram
// ----------------------------------------------------------------------------
`default_nettype none
`include "first_fit_heap_allocator_defines.svh"

module ffha_engine #(
   parameter int HEAP_UNITS = ffha_pkg::HEAP_UNITS_DEF,
   parameter int UNIT_BYTES = ffha_pkg::UNIT_BYTES_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic                        req_operation,
   input  wire logic [ffha_pkg::SIZE_W-1:0] req_size_bytes,
   input  wire logic [ffha_pkg::ADDR_W-1:0] req_payload_address,
   output ffha_pkg::eng_rsp_type            eng_rsp,
   input  wire logic                        out_free
);

   import ffha_pkg::*;

   localparam int AW = $clog2(HEAP_UNITS);
   localparam int DW = 2 * AW + 2;
   localparam int CW = $clog2(HEAP_UNITS + 1);
   localparam int UW = SIZE_W + 1;
   localparam int EW = ((AW > UW) ? AW : UW) + 1;
   localparam logic [AW-1:0] LAST     = AW'(HEAP_UNITS - 1);
   localparam logic [CW-1:0] STEP_MAX = CW'(HEAP_UNITS);

   state_type state_ff, state_in;

   logic [AW-1:0]       clr_ff, clr_in;
   logic [AW-1:0]       h_ff, h_in;
   logic [AW-1:0]       n_ff, n_in;
   logic [AW-1:0]       p_ff, p_in;
   logic [AW-1:0]       s_ff, s_in;
   logic [CW-1:0]       steps_ff, steps_in;
   logic [DW-1:0]       en_ff, en_in;
   logic [DW-1:0]       ep_ff, ep_in;
   logic                n_free_ff, n_free_in;
   logic                p_merge_ff, p_merge_in;
   logic [ADDR_W-1:0]   res_addr_ff, res_addr_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [DW-1:0] ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic [DW-1:0] ram_rdata;

   logic          div_start;
   logic          div_done;
   logic [UW-1:0] div_units;

   // header word: in-header mark, used mark, next link, previous link
   logic          rd_hdr;
   logic          rd_used;
   logic [AW-1:0] rd_next;
   logic [AW-1:0] rd_prev;
   logic [EW-1:0] end_w;
   logic          fit;
   logic          split;
   logic [AW-1:0] s_word;
   logic [AW-1:0] nx;
   logic          addr_bad;
   logic [AW-1:0] addr_h;
   logic [ADDR_W-1:0] h_plus;

   ffha_ram #(
      .WIDTH (DW),
      .DEPTH (HEAP_UNITS)
   ) u_hdr_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   ffha_units_div #(
      .UNIT_BYTES (UNIT_BYTES)
   ) u_units_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .bytes (req_size_bytes),
      .done  (div_done),
      .units (div_units)
   );

   assign rd_hdr  = ram_rdata[DW-1];
   assign rd_used = ram_rdata[DW-2];
   assign rd_next = ram_rdata[2*AW-1:AW];
   assign rd_prev = ram_rdata[AW-1:0];

   assign end_w  = EW'(h_ff) + EW'(1) + EW'(div_units);
   assign fit    = !rd_used && (end_w <= EW'(rd_next));
   assign split  = end_w < EW'(rd_next);
   assign s_word = AW'(end_w);
   assign h_plus = ADDR_W'(32'(h_ff) + 32'd1);

   // link that follows the freed block once a free next neighbour is absorbed
   assign nx = n_free_ff ? en_ff[2*AW-1:AW] : n_ff;

   assign addr_bad = (req_payload_address == '0) ||
                     (32'(req_payload_address) >= 32'(HEAP_UNITS));
   assign addr_h   = AW'(32'(req_payload_address) - 32'd1);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      h_in          = h_ff;
      n_in          = n_ff;
      p_in          = p_ff;
      s_in          = s_ff;
      steps_in      = steps_ff;
      en_in         = en_ff;
      ep_in         = ep_ff;
      n_free_in     = n_free_ff;
      p_merge_in    = p_merge_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      ram_we        = 1'b0;
      ram_waddr     = h_ff;
      ram_wdata     = '0;
      ram_raddr     = h_ff;
      div_start     = 1'b0;
      req_ready     = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            if (clr_ff == '0) begin
               ram_wdata = {1'b1, 1'b0, LAST, {AW{1'b0}}};
            end else if (clr_ff == LAST) begin
               ram_wdata = {1'b1, 1'b1, {AW{1'b0}}, {AW{1'b0}}};
            end
            clr_in = clr_ff + AW'(1);
            if (clr_ff == LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_operation == OP_ALLOC) begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end else if (addr_bad) begin
                  res_addr_in   = '0;
                  res_status_in = STATUS_BAD_ADDR;
                  state_in      = ST_DONE;
               end else begin
                  h_in      = addr_h;
                  ram_raddr = addr_h;
                  state_in  = ST_FREE_H;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               h_in     = '0;
               steps_in = '0;
               state_in = ST_WALK_RD;
            end
         end
         ST_WALK_RD: begin
            if (h_ff == LAST || steps_ff == STEP_MAX) begin
               res_addr_in   = '0;
               res_status_in = STATUS_NO_SPACE;
               state_in      = ST_DONE;
            end else begin
               ram_raddr = h_ff;
               state_in  = ST_WALK_CHK;
            end
         end
         ST_WALK_CHK: begin
            if (fit) begin
               ram_we        = 1'b1;
               ram_waddr     = h_ff;
               ram_wdata     = {rd_hdr, 1'b1, (split ? s_word : rd_next), rd_prev};
               res_addr_in   = h_plus;
               res_status_in = STATUS_OK;
               n_in          = rd_next;
               s_in          = s_word;
               if (split) begin
                  ram_raddr = rd_next;
                  state_in  = ST_SPLIT_LINK;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               h_in     = rd_next;
               steps_in = steps_ff + CW'(1);
               state_in = ST_WALK_RD;
            end
         end
         ST_SPLIT_LINK: begin
            ram_we    = 1'b1;
            ram_waddr = n_ff;
            ram_wdata = {ram_rdata[DW-1:AW], s_ff};
            state_in  = ST_SPLIT_NEW;
         end
         ST_SPLIT_NEW: begin
            ram_we    = 1'b1;
            ram_waddr = s_ff;
            ram_wdata = {1'b1, 1'b0, n_ff, h_ff};
            state_in  = ST_DONE;
         end
         ST_FREE_H: begin
            res_addr_in = '0;
            if (!rd_hdr) begin
               res_status_in = STATUS_BAD_ADDR;
               state_in      = ST_DONE;
            end else if (h_ff == LAST || !rd_used) begin
               res_status_in = STATUS_NOT_IN_USE;
               state_in      = ST_DONE;
            end else begin
               n_in      = rd_next;
               p_in      = rd_prev;
               ram_raddr = rd_next;
               state_in  = ST_FREE_N;
            end
         end
         ST_FREE_N: begin
            en_in     = ram_rdata;
            n_free_in = !rd_used;
            if (h_ff != '0) begin
               ram_raddr = p_ff;
               state_in  = ST_FREE_P;
            end else begin
               // the first block has no previous neighbour
               p_merge_in = 1'b0;
               state_in   = ST_FREE_WH;
            end
         end
         ST_FREE_P: begin
            ep_in      = ram_rdata;
            p_merge_in = !rd_used;
            state_in   = ST_FREE_WH;
         end
         ST_FREE_WH: begin
            ram_we    = 1'b1;
            ram_waddr = h_ff;
            ram_wdata = {!p_merge_ff, 1'b0, nx, p_ff};
            ram_raddr = nx;
            state_in  = ST_FREE_WX;
         end
         ST_FREE_WX: begin
            if (n_free_ff || p_merge_ff) begin
               ram_we    = 1'b1;
               ram_waddr = nx;
               ram_wdata = {ram_rdata[DW-1:AW], (p_merge_ff ? p_ff : h_ff)};
            end
            state_in = ST_FREE_WN;
         end
         ST_FREE_WN: begin
            if (n_free_ff) begin
               ram_we    = 1'b1;
               ram_waddr = n_ff;
               ram_wdata = {1'b0, en_ff[DW-2:0]};
            end
            state_in = ST_FREE_WP;
         end
         ST_FREE_WP: begin
            if (p_merge_ff) begin
               ram_we    = 1'b1;
               ram_waddr = p_ff;
               ram_wdata = {ep_ff[DW-1:2*AW], nx, ep_ff[AW-1:0]};
            end
            res_addr_in   = '0;
            res_status_in = STATUS_OK;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      h_ff          <= h_in;
      n_ff          <= n_in;
      p_ff          <= p_in;
      s_ff          <= s_in;
      steps_ff      <= steps_in;
      en_ff         <= en_in;
      ep_ff         <= ep_in;
      n_free_ff     <= n_free_in;
      p_merge_ff    <= p_merge_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
   end

   assign eng_rsp.valid          = (state_ff == ST_DONE);
   assign eng_rsp.result_address = res_addr_ff;
   assign eng_rsp.status         = res_status_ff;

   `FFHA_ASSERT(a_wr_in_heap, clock, reset, ram_we |-> (ram_waddr <= LAST), "header write outside the heap")
   `FFHA_ASSERT(a_fail_null, clock, reset, (state_ff == ST_DONE && res_status_ff != STATUS_OK) |-> (res_addr_ff == '0), "failed transfer carries an address")
   `FFHA_ASSERT(a_split_order, clock, reset, (state_ff == ST_SPLIT_NEW) |-> (s_ff > h_ff && s_ff < n_ff), "split header outside its block")
   `FFHA_ASSERT_NEXT(a_split_link, clock, reset, (state_ff == ST_WALK_CHK && fit && split), (ram_we && ram_waddr == $past(rd_next)), "split did not relink the next header")

endmodule

`default_nettype wire

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: first fit heap allocator regression
// drives allocate and free requests over the req channel and checks every rsp
// transfer against a cycle-free model of the header chain kept in the bench
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   import ffha_pkg::*;

   localparam int HEAP_UNITS = HEAP_UNITS_DEF;
   localparam int UNIT_BYTES = UNIT_BYTES_DEF;
   localparam int LAST_UNIT  = HEAP_UNITS - 1;
   localparam int SETTLE_CYCLES = 64;
   localparam int FREED_KEEP = 16;

   typedef struct packed {
      logic                op;
      logic [ADDR_W-1:0]   address;
      logic [STATUS_W-1:0] status;
   } heap_reply_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_operation;
   logic [SIZE_W-1:0]   req_size_bytes;
   logic [ADDR_W-1:0]   req_payload_address;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [ADDR_W-1:0]   rsp_result_address;
   logic [STATUS_W-1:0] rsp_status;

   // model of the header chain
   logic              heap_is_hdr [HEAP_UNITS];
   logic              heap_used   [HEAP_UNITS];
   logic [ADDR_W-1:0] heap_next   [HEAP_UNITS];
   logic [ADDR_W-1:0] heap_prev   [HEAP_UNITS];

   heap_reply_type      pending_replies[$];
   logic [ADDR_W-1:0]   live_blocks[$];
   logic [ADDR_W-1:0]   freed_blocks[$];
   logic [STATUS_W-1:0] last_status;

   int unsigned error_count = 0;
   int unsigned rsp_hold_cycles = 0;
   bit          req_idle_on = 1'b1;
   bit          rsp_idle_on = 1'b1;

   first_fit_heap_allocator dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_size_bytes      (req_size_bytes),
      .req_payload_address (req_payload_address),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_result_address  (rsp_result_address),
      .rsp_status          (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("first_fit_heap_allocator regression: fail");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic void heap_model_reset();
      for (int i = 0; i < HEAP_UNITS; i++) begin
         heap_is_hdr[i] = 1'b0;
         heap_used[i]   = 1'b0;
         heap_next[i]   = '0;
         heap_prev[i]   = '0;
      end
      heap_is_hdr[0]         = 1'b1;
      heap_is_hdr[LAST_UNIT] = 1'b1;
      heap_used[LAST_UNIT]   = 1'b1;
      heap_next[0]           = ADDR_W'(LAST_UNIT);
   endfunction

   function automatic void heap_model_alloc(input logic [SIZE_W-1:0] bytes,
                                            output logic [ADDR_W-1:0] addr,
                                            output logic [STATUS_W-1:0] st);
      int unsigned units;
      int unsigned h;
      int unsigned n;
      int unsigned stop;
      units = bytes / UNIT_BYTES;
      if (bytes % UNIT_BYTES != 0) units++;
      if (units == 0) units = 1;
      h    = 0;
      addr = '0;
      st   = STATUS_NO_SPACE;
      for (int steps = 0; steps < HEAP_UNITS; steps++) begin
         if (h == LAST_UNIT) break;
         n    = heap_next[h];
         stop = h + 1 + units;
         if (!heap_used[h] && stop <= n) begin
            // remainder becomes a new free block right after the payload
            if (stop < n) begin
               heap_is_hdr[stop] = 1'b1;
               heap_used[stop]   = 1'b0;
               heap_next[stop]   = ADDR_W'(n);
               heap_prev[stop]   = ADDR_W'(h);
               heap_prev[n]      = ADDR_W'(stop);
               heap_next[h]      = ADDR_W'(stop);
            end
            heap_used[h] = 1'b1;
            addr = ADDR_W'(h + 1);
            st   = STATUS_OK;
            return;
         end
         h = n;
      end
   endfunction

   function automatic logic [STATUS_W-1:0] heap_model_free(input logic [ADDR_W-1:0] addr);
      int unsigned h;
      int unsigned n;
      int unsigned nn;
      int unsigned p;
      int unsigned nx;
      if (addr == 0 || addr >= HEAP_UNITS) return STATUS_BAD_ADDR;
      h = addr - 1;
      if (!heap_is_hdr[h]) return STATUS_BAD_ADDR;
      if (h == LAST_UNIT || !heap_used[h]) return STATUS_NOT_IN_USE;
      heap_used[h] = 1'b0;
      n = heap_next[h];
      if (!heap_used[n]) begin
         nn = heap_next[n];
         heap_is_hdr[n] = 1'b0;
         heap_next[h]   = ADDR_W'(nn);
         heap_prev[nn]  = ADDR_W'(h);
      end
      // unit 0 has no previous neighbour
      if (h != 0) begin
         p = heap_prev[h];
         if (!heap_used[p]) begin
            nx = heap_next[h];
            heap_next[p]   = ADDR_W'(nx);
            heap_prev[nx]  = ADDR_W'(p);
            heap_is_hdr[h] = 1'b0;
         end
      end
      return STATUS_OK;
   endfunction

   function automatic void predict_reply(input logic op, input logic [SIZE_W-1:0] size,
                                         input logic [ADDR_W-1:0] addr);
      heap_reply_type r;
      r.op = op;
      if (op == OP_ALLOC) begin
         heap_model_alloc(size, r.address, r.status);
         if (r.status == STATUS_OK) live_blocks.push_back(r.address);
      end else begin
         r.address = '0;
         r.status  = heap_model_free(addr);
         if (r.status == STATUS_OK) begin
            for (int i = 0; i < live_blocks.size(); i++) begin
               if (live_blocks[i] == addr) begin
                  live_blocks.delete(i);
                  break;
               end
            end
            freed_blocks.push_back(addr);
            if (freed_blocks.size() > FREED_KEEP) void'(freed_blocks.pop_front());
         end
      end
      last_status = r.status;
      pending_replies.push_back(r);
   endfunction

   task automatic send_req(input logic op, input logic [SIZE_W-1:0] size,
                           input logic [ADDR_W-1:0] addr);
      int unsigned gap;
      gap = req_idle_on ? $urandom_range(0, 14) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid           <= 1'b1;
      req_operation       <= op;
      req_size_bytes      <= size;
      req_payload_address <= addr;
      do @(posedge clock); while (!req_ready);
      predict_reply(op, size, addr);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // receiver side: random stall before each transfer, or a long hold on request
   initial begin : rsp_side
      int unsigned gap;
      rsp_ready = 1'b0;
      forever begin
         gap = rsp_idle_on ? $urandom_range(0, 14) : 0;
         if (rsp_hold_cycles != 0) begin
            gap = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         repeat (gap) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready) && rsp_hold_cycles == 0);
      end
   end

   always @(posedge clock) begin : reply_checker
      heap_reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_replies.size() == 0) begin
            report_mismatch($sformatf("unexpected transfer: address %0d status %0d",
                                      rsp_result_address, rsp_status));
         end else begin
            want = pending_replies.pop_front();
            if (rsp_result_address !== want.address)
               report_mismatch($sformatf("op %0d: result_address %0d, want %0d",
                                         want.op, rsp_result_address, want.address));
            if (rsp_status !== want.status)
               report_mismatch($sformatf("op %0d: status %0d, want %0d",
                                         want.op, rsp_status, want.status));
         end
      end
   end

   task automatic test_directed_cases();
      send_req(OP_ALLOC, 16'd0, '0);          // zero bytes still takes one unit
      send_req(OP_ALLOC, 16'd1, '0);
      send_req(OP_ALLOC, 16'd16, '0);
      send_req(OP_ALLOC, 16'd17, '0);
      send_req(OP_ALLOC, 16'hFFFF, '1);       // far too large
      send_req(OP_FREE, 16'hFFFF, 10'd0);     // null
      send_req(OP_FREE, '0, 10'd1023);        // inside the free block, not a header
      send_req(OP_FREE, '0, 10'd8);           // middle of a payload
      send_req(OP_FREE, '0, 10'd3);
      send_req(OP_FREE, '0, 10'd3);           // double free
      send_req(OP_ALLOC, 16'd16, '0);         // exact fit of the freed block
      send_req(OP_FREE, '0, 10'd5);
      send_req(OP_FREE, '0, 10'd3);           // merges with next
      send_req(OP_FREE, '0, 10'd1);           // first block merges with next
      send_req(OP_FREE, '0, 10'd7);           // merges both ways
      send_req(OP_ALLOC, 16'd16352, '0);      // whole heap, exact
      send_req(OP_ALLOC, 16'd0, '0);          // nothing left
      send_req(OP_FREE, '0, 10'd1);
      send_req(OP_ALLOC, 16'd16353, '0);      // one unit too many
      send_req(OP_ALLOC, 16'd15, 10'h2AA);
      send_req(OP_FREE, 16'h5555, 10'd1);
   endtask

   task automatic test_back_pressure();
      drain_results();
      req_idle_on = 1'b0;
      @(negedge clock);
      rsp_hold_cycles = 300;
      repeat (8) send_req(OP_ALLOC, 16'($urandom_range(0, 64)), 10'($urandom));
      repeat (6) begin
         if (live_blocks.size() != 0)
            send_req(OP_FREE, 16'($urandom), live_blocks[$urandom_range(0, live_blocks.size()-1)]);
      end
      req_idle_on = 1'b1;
      drain_results();
   endtask

   task automatic test_fill_and_release();
      int unsigned misses;
      int unsigned tries;
      logic [ADDR_W-1:0] a;
      misses = 0;
      tries  = 0;
      while (misses < 3 && tries < 300) begin
         send_req(OP_ALLOC, 16'($urandom_range(0, 400)), 10'($urandom));
         if (last_status == STATUS_NO_SPACE) misses++;
         tries++;
      end
      while (live_blocks.size() != 0) begin
         a = live_blocks[$urandom_range(0, live_blocks.size()-1)];
         send_req(OP_FREE, 16'($urandom), a);
         if ($urandom_range(0, 7) == 0) send_req(OP_FREE, 16'($urandom), a);
      end
      send_req(OP_ALLOC, 16'd16352, '0);
      if (last_status == STATUS_OK) send_req(OP_FREE, '0, 10'd1);
   endtask

   task automatic test_random_traffic(input int unsigned count);
      int unsigned kind;
      int unsigned alloc_cut;
      logic [SIZE_W-1:0] size;
      for (int i = 0; i < count; i++) begin
         // change the idling mix every so often, including stretches with none
         if (i % 80 == 0) begin
            case ($urandom_range(0, 3))
               0: begin req_idle_on = 1'b1; rsp_idle_on = 1'b1; end
               1: begin req_idle_on = 1'b1; rsp_idle_on = 1'b0; end
               2: begin req_idle_on = 1'b0; rsp_idle_on = 1'b1; end
               default: begin req_idle_on = 1'b0; rsp_idle_on = 1'b0; end
            endcase
         end
         kind      = $urandom_range(0, 99);
         alloc_cut = (live_blocks.size() > 40) ? 30 : 50;
         if (kind < alloc_cut || (kind < 88 && live_blocks.size() == 0)) begin
            case ($urandom_range(0, 19))
               18:      size = 16'($urandom_range(0, 16352));
               19:      size = 16'($urandom_range(0, 65535));
               14, 15, 16, 17: size = 16'($urandom_range(0, 1024));
               default: size = 16'($urandom_range(0, 128));
            endcase
            send_req(OP_ALLOC, size, 10'($urandom));
         end else if (kind < 88) begin
            send_req(OP_FREE, 16'($urandom),
                     live_blocks[$urandom_range(0, live_blocks.size()-1)]);
         end else if (kind < 94 && freed_blocks.size() != 0) begin
            // stale address: double free, or a block taken again since
            send_req(OP_FREE, 16'($urandom),
                     freed_blocks[$urandom_range(0, freed_blocks.size()-1)]);
         end else begin
            send_req(OP_FREE, 16'($urandom), 10'($urandom));
         end
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   initial begin : main
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_operation       = OP_ALLOC;
      req_size_bytes      = '0;
      req_payload_address = '0;
      heap_model_reset();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_back_pressure();
      test_fill_and_release();
      test_random_traffic(600);
      drain_results();
      if (error_count == 0) begin
         $display("first_fit_heap_allocator regression: pass");
      end else begin
         $display("first_fit_heap_allocator regression: fail");
      end
      $finish;
   end

endmodule
